FILE: hdl/dis_pkg.sv
package dis_pkg;

    localparam int MAX_RANGES = 64;
    localparam int VALUE_BITS = 32;
    localparam int IDX_W      = $clog2(MAX_RANGES);
    localparam int CNT_W      = $clog2(MAX_RANGES + 2);
    localparam int ADDR_W     = IDX_W + 1;
    localparam int OP_W       = 3;
    localparam int ST_W       = 2;
    localparam int CFG_IDX_W  = 1;

    typedef logic [VALUE_BITS-1:0] t_value;

    typedef struct packed {
        t_value lo;
        t_value hi;
    } t_entry;

    localparam logic [OP_W-1:0] OP_ADD        = 3'd0;
    localparam logic [OP_W-1:0] OP_REMOVE     = 3'd1;
    localparam logic [OP_W-1:0] OP_CONTAINS   = 3'd2;
    localparam logic [OP_W-1:0] OP_INTERSECTS = 3'd3;
    localparam logic [OP_W-1:0] OP_NEXT       = 3'd4;
    localparam logic [OP_W-1:0] OP_MEX        = 3'd5;

    localparam logic [ST_W-1:0] ST_OK     = 2'd0;
    localparam logic [ST_W-1:0] ST_BOUNDS = 2'd1;
    localparam logic [ST_W-1:0] ST_FULL   = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_LOW_SENTINEL  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_HIGH_SENTINEL = 1'b1;

    typedef struct packed {
        logic [OP_W-1:0] opcode;
        t_value          range_low;
        t_value          range_high;
    } t_in_item;

    typedef struct packed {
        t_value           changed_count;
        logic             hit;
        t_value           found_low;
        t_value           found_high;
        t_value           total_length;
        logic [CNT_W-1:0] num_ranges;
        logic [ST_W-1:0]  status;
    } t_out_item;

endpackage

FILE: hdl/dis_table_mem.sv
module dis_table_mem (
    input  logic                       i_clk,
    input  logic                       i_we,
    input  logic [dis_pkg::ADDR_W-1:0] i_waddr,
    input  dis_pkg::t_entry            i_wdata,
    input  logic [dis_pkg::ADDR_W-1:0] i_raddr,
    output dis_pkg::t_entry            o_rdata
);
    import dis_pkg::*;

    // two banks: the live table and the one being rebuilt
    t_entry r_mem [2**ADDR_W];
    t_entry r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: hdl/disjoint_interval_set_core.sv
// Channel   Direction  Handshake                 Payload
// command   in         start & !busy             i_item   (t_in_item)
// result    out        o_valid, one cycle        o_result (t_out_item)
// config    in         i_cfg_we                  i_cfg_idx, i_cfg_data
//
// A rejected item, an empty add/remove/intersects and an empty contains answer
// straight from the idle state. Others walk the stored table through one compare
// unit: each stored range is read (S_RD) and compared (S_EX), an extra write
// (insert or split) adds S_EX2, and S_TAIL finishes; the single table port serialises the walk.
// Updates rebuild into the spare bank and flip on commit. Reset clears the range
// count and total; table contents are never read before being written.
// The receiver cannot stall: each result beat shows on o_valid for one cycle.
module disjoint_interval_set_core (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  dis_pkg::t_in_item             i_item,
    output logic                          o_valid,
    output dis_pkg::t_out_item            o_result,
    input  logic                          i_cfg_we,
    input  logic [dis_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  dis_pkg::t_value               i_cfg_data
);
    import dis_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_RD   = 5'b00010,
        S_EX   = 5'b00100,
        S_EX2  = 5'b01000,
        S_TAIL = 5'b10000
    } t_state;

    t_state           r_state, n_state;
    logic             r_bank, n_bank;
    logic [CNT_W-1:0] r_i, n_i;
    logic [CNT_W-1:0] r_n, n_n;
    t_value           r_sum, n_sum;
    t_value           r_l, n_l;
    t_value           r_r, n_r;
    logic             r_placed, n_placed;
    logic [OP_W-1:0]  r_op, n_op;
    logic             r_hit, n_hit;
    t_value           r_flo, n_flo;
    t_value           r_fhi, n_fhi;
    t_entry           r_pend, n_pend;
    logic [CNT_W-1:0] r_stored, n_stored;
    t_value           r_total, n_total;
    t_value           r_low_sent, r_high_sent;
    logic             r_valid, n_valid;
    t_out_item        r_result, n_result;

    logic   we;
    t_entry wdata;
    t_entry rdata;
    logic   mem_we;
    logic   range_ok, point_ok;
    t_value s, e;

    assign s = rdata.lo;
    assign e = rdata.hi;
    assign mem_we = we && (r_n < CNT_W'(MAX_RANGES));

    dis_table_mem u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr ({~r_bank, r_n[IDX_W-1:0]}),
        .i_wdata (wdata),
        .i_raddr ({r_bank, r_i[IDX_W-1:0]}),
        .o_rdata (rdata)
    );

    assign range_ok = (r_low_sent < i_item.range_low) &&
                      (i_item.range_low <= i_item.range_high) &&
                      (i_item.range_high <= r_high_sent);
    assign point_ok = (r_low_sent < i_item.range_low) &&
                      (i_item.range_low < r_high_sent);

    always_comb begin
        n_state  = r_state;
        n_bank   = r_bank;
        n_i      = r_i;
        n_n      = r_n;
        n_sum    = r_sum;
        n_l      = r_l;
        n_r      = r_r;
        n_placed = r_placed;
        n_op     = r_op;
        n_hit    = r_hit;
        n_flo    = r_flo;
        n_fhi    = r_fhi;
        n_pend   = r_pend;
        n_stored = r_stored;
        n_total  = r_total;
        n_valid  = 1'b0;
        n_result = r_result;
        we       = 1'b0;
        wdata    = '{lo: r_l, hi: r_r};

        case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_op     = i_item.opcode;
                    n_l      = i_item.range_low;
                    n_r      = i_item.range_high;
                    n_i      = '0;
                    n_n      = '0;
                    n_sum    = '0;
                    n_placed = 1'b0;
                    n_hit    = 1'b0;
                    n_flo    = '0;
                    n_fhi    = '0;
                    n_result = '{changed_count: '0, hit: 1'b0, found_low: '0,
                                 found_high: '0, total_length: r_total,
                                 num_ranges: r_stored, status: ST_OK};
                    if (i_item.opcode == OP_NEXT) begin
                        n_flo = r_high_sent;
                        n_fhi = r_high_sent;
                    end else if (i_item.opcode == OP_MEX) begin
                        n_flo = i_item.range_low;
                    end
                    case (i_item.opcode)
                        OP_ADD, OP_REMOVE, OP_CONTAINS, OP_INTERSECTS: begin
                            if (!range_ok) begin
                                n_result.status = ST_BOUNDS;
                                n_valid = 1'b1;
                            end else if (i_item.range_low == i_item.range_high) begin
                                // empty range: contains is true, the rest are no-ops
                                n_result.hit = (i_item.opcode == OP_CONTAINS);
                                n_valid = 1'b1;
                            end else begin
                                n_state = (r_stored == '0) ? S_TAIL : S_RD;
                            end
                        end
                        OP_NEXT, OP_MEX: begin
                            if (!point_ok) begin
                                n_result.status = ST_BOUNDS;
                                n_valid = 1'b1;
                            end else begin
                                n_state = (r_stored == '0) ? S_TAIL : S_RD;
                            end
                        end
                        default: begin
                            n_result.status = ST_BOUNDS;
                            n_valid = 1'b1;
                        end
                    endcase
                end
            end
            S_RD: begin
                n_state = S_EX;
            end
            S_EX: begin
                n_i     = r_i + CNT_W'(1);
                n_state = (r_i == r_stored - CNT_W'(1)) ? S_TAIL : S_RD;
                case (r_op)
                    OP_ADD: begin
                        if (e < r_l) begin
                            we    = 1'b1;
                            wdata = rdata;
                        end else if (s <= r_r) begin
                            // merge overlapping or touching entry
                            if (s < r_l) n_l = s;
                            if (e > r_r) n_r = e;
                        end else if (!r_placed) begin
                            we       = 1'b1;
                            n_placed = 1'b1;
                            n_pend   = rdata;
                            n_state  = S_EX2;
                        end else begin
                            we    = 1'b1;
                            wdata = rdata;
                        end
                    end
                    OP_REMOVE: begin
                        if (e <= r_l || s >= r_r) begin
                            we    = 1'b1;
                            wdata = rdata;
                        end else if (s < r_l) begin
                            we    = 1'b1;
                            wdata = '{lo: s, hi: r_l};
                            if (e > r_r) begin
                                // split: hold the right piece for the next cycle
                                n_pend  = '{lo: r_r, hi: e};
                                n_state = S_EX2;
                            end
                        end else if (e > r_r) begin
                            we    = 1'b1;
                            wdata = '{lo: r_r, hi: e};
                        end
                    end
                    OP_CONTAINS: begin
                        if (s <= r_l && r_l < e && r_r <= e) n_hit = 1'b1;
                    end
                    OP_INTERSECTS: begin
                        if (s < r_r && e > r_l) n_hit = 1'b1;
                    end
                    OP_NEXT: begin
                        if (!r_hit && e > r_l) begin
                            n_hit = 1'b1;
                            n_flo = s;
                            n_fhi = e;
                        end
                    end
                    default: begin
                        if (s <= r_l && r_l < e) n_flo = e;
                    end
                endcase
            end
            S_EX2: begin
                we      = 1'b1;
                wdata   = r_pend;
                n_state = (r_i == r_stored) ? S_TAIL : S_RD;
            end
            S_TAIL: begin
                if (r_op == OP_ADD && !r_placed) begin
                    we = 1'b1;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        if (we) begin
            n_n   = (r_n > CNT_W'(MAX_RANGES)) ? r_n : r_n + CNT_W'(1);
            n_sum = r_sum + (wdata.hi - wdata.lo);
        end

        if (r_state == S_TAIL) begin
            n_state  = S_IDLE;
            n_valid  = 1'b1;
            n_result = '{changed_count: '0, hit: 1'b0, found_low: '0, found_high: '0,
                         total_length: r_total, num_ranges: r_stored, status: ST_OK};
            case (r_op)
                OP_ADD, OP_REMOVE: begin
                    if (n_n > CNT_W'(MAX_RANGES)) begin
                        n_result.status = ST_FULL;
                    end else begin
                        // commit: flip to the rebuilt bank
                        n_bank   = ~r_bank;
                        n_stored = n_n;
                        n_total  = n_sum;
                        n_result.total_length  = n_sum;
                        n_result.num_ranges    = n_n;
                        n_result.changed_count = (r_op == OP_ADD) ? n_sum - r_total
                                                                  : r_total - n_sum;
                    end
                end
                OP_CONTAINS, OP_INTERSECTS: begin
                    n_result.hit = r_hit;
                end
                OP_NEXT: begin
                    n_result.hit        = r_hit;
                    n_result.found_low  = r_flo;
                    n_result.found_high = r_fhi;
                end
                default: begin
                    n_result.found_low = r_flo;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_bank      <= 1'b0;
            r_stored    <= '0;
            r_total     <= '0;
            r_valid     <= 1'b0;
            r_low_sent  <= '0;
            r_high_sent <= '1;
        end else begin
            r_state  <= n_state;
            r_bank   <= n_bank;
            r_stored <= n_stored;
            r_total  <= n_total;
            r_valid  <= n_valid;
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_LOW_SENTINEL:  r_low_sent  <= i_cfg_data;
                    CFG_HIGH_SENTINEL: r_high_sent <= i_cfg_data;
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_i      <= n_i;
        r_n      <= n_n;
        r_sum    <= n_sum;
        r_l      <= n_l;
        r_r      <= n_r;
        r_placed <= n_placed;
        r_op     <= n_op;
        r_hit    <= n_hit;
        r_flo    <= n_flo;
        r_fhi    <= n_fhi;
        r_pend   <= n_pend;
        r_result <= n_result;
    end

    assign busy     = (r_state != S_IDLE);
    assign o_valid  = r_valid;
    assign o_result = r_result;

endmodule
